/* rtl/dssf_pkg.sv */
// ----------------------------------------------------------------------------
// dssf_pkg
// Shared types, sizes and the segment table of the decimal seven-segment
// formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package dssf_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int DIGIT_SLOTS    = 24;
   // decimal digits of the largest positive value: floor(bits * log10 2) + 1
   localparam int DIGIT_CELLS    = (VALUE_BITS * 302) / 1000 + 1;
   localparam int RUN_CAP        = DIGIT_SLOTS - 1;
   // digit counts, positions and padding all stay below 32
   localparam int CNT_BITS       = 5;
   localparam int BIT_CNT_BITS   = $clog2(VALUE_BITS);
   localparam int REQ_DATA_BITS  = ((VALUE_BITS + 9 + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = 8;

   localparam logic [4:0] MAX_MIN_DIGITS = 5'd16;
   localparam logic [7:0] POINT_BIT      = 8'h80;

   localparam logic [1:0] OP_INT   = 2'd0;
   localparam logic [1:0] OP_FIXED = 2'd1;
   localparam logic [1:0] OP_RAW   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_COUNT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   function automatic logic [6:0] seg_of(input logic [3:0] digit);
      logic [6:0] seg;
      unique case (digit)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

/* rtl/decimal_seven_segment_formatter.sv */
// ----------------------------------------------------------------------------
// decimal_seven_segment_formatter
// Turns a number into a run of seven-segment bytes, most significant first.
// ----------------------------------------------------------------------------
// One request at a time. A digit request is loaded, shifted bit by bit through
// the BCD cell chain (VALUE_BITS bits, 32), sized, and then emitted one byte
// per accepted beat, with up to 23 bytes in the run. A raw request sends a single
// byte; a request with no bytes (negative value with no padding, undefined
// op) ends with no response. The conversion is a bit-serial shift through
// the digit cells.
`default_nettype none

module decimal_seven_segment_formatter (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // value, decimal_places, min_digits, shown, zero fill
   input  wire [dssf_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // op
   input  wire [1:0]                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // segments
   output logic [dssf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int VB = dssf_pkg::VALUE_BITS;
   localparam int NC = dssf_pkg::DIGIT_CELLS;
   localparam int CB = dssf_pkg::CNT_BITS;
   localparam int BB = dssf_pkg::BIT_CNT_BITS;

   dssf_pkg::state_type state_ff, state_in;

   logic [VB-1:0] mag_ff,     mag_in;
   logic [BB-1:0] bit_cnt_ff, bit_cnt_in;
   logic [CB-1:0] pos_ff,     pos_in;
   logic [CB-1:0] pad_ff,     pad_in;
   logic [2:0]    dp_ff,      dp_in;
   logic [7:0]    raw_ff,     raw_in;
   logic          fixed_ff,   fixed_in;
   logic          is_raw_ff,  is_raw_in;
   logic          shown_ff,   shown_in;
   logic          nonneg_ff,  nonneg_in;

   logic                    accept;
   logic                    beat_out;
   dssf_pkg::cell_ctrl_type cell_ctrl;
   logic [NC:0]             carry;
   logic [3:0]              digits [NC];

   logic [VB-1:0] req_value;
   logic [2:0]    req_dp;
   logic [4:0]    req_mind;
   logic          req_shown;
   logic [4:0]    mind_c;

   logic [CB-1:0] hi;
   logic [CB-1:0] ndig;
   logic [CB-1:0] run_len;
   logic [3:0]    cur_digit;
   logic [6:0]    cur_seg;

   assign req_value = req_tdata[VB-1:0];
   assign req_dp    = req_tdata[VB+2:VB];
   assign req_mind  = req_tdata[VB+7:VB+3];
   assign req_shown = req_tdata[VB+8];

   assign accept   = req_tvalid && req_tready;
   assign beat_out = rsp_tvalid && rsp_tready;

   // digit chain
   assign cell_ctrl.clear = accept;
   assign cell_ctrl.shift = (state_ff == dssf_pkg::ST_CONVERT);
   assign carry[0]        = mag_ff[VB-1];

   for (genvar i = 0; i < NC; i++) begin : g_cell
      dssf_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .carry_in  (carry[i]),
         .carry_out (carry[i+1]),
         .digit     (digits[i])
      );
   end

   // run sizing
   always_comb begin
      hi = '0;
      for (int i = 0; i < NC; i++) begin
         if (digits[i] != 4'd0) begin
            hi = CB'(i + 1);
         end
      end
      ndig = (hi == '0 && nonneg_ff) ? CB'(1) : hi;
      run_len = (ndig > pad_ff) ? ndig : pad_ff;
      if (run_len > CB'(dssf_pkg::RUN_CAP)) begin
         run_len = CB'(dssf_pkg::RUN_CAP);
      end
   end

   always_comb begin
      cur_digit = 4'd0;
      for (int i = 0; i < NC; i++) begin
         if (pos_ff == CB'(i)) begin
            cur_digit = digits[i];
         end
      end
      cur_seg = dssf_pkg::seg_of(cur_digit);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dssf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser == dssf_pkg::OP_RAW) begin
                  state_in = dssf_pkg::ST_EMIT;
               end else if (req_tuser == dssf_pkg::OP_INT ||
                            req_tuser == dssf_pkg::OP_FIXED) begin
                  state_in = dssf_pkg::ST_CONVERT;
               end
            end
         end
         dssf_pkg::ST_CONVERT: begin
            if (bit_cnt_ff == '0) begin
               state_in = dssf_pkg::ST_COUNT;
            end
         end
         dssf_pkg::ST_COUNT: begin
            state_in = (run_len == '0) ? dssf_pkg::ST_IDLE : dssf_pkg::ST_EMIT;
         end
         dssf_pkg::ST_EMIT: begin
            if (beat_out && rsp_tlast) begin
               state_in = dssf_pkg::ST_IDLE;
            end
         end
         default: state_in = dssf_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == dssf_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == dssf_pkg::ST_EMIT);
      rsp_tlast  = is_raw_ff || (pos_ff == '0);
      if (is_raw_ff) begin
         rsp_tdata = raw_ff;
      end else if (shown_ff) begin
         rsp_tdata = {1'b0, cur_seg};
         if (fixed_ff && pos_ff == CB'(dp_ff)) begin
            rsp_tdata = rsp_tdata | dssf_pkg::POINT_BIT;
         end
      end else begin
         rsp_tdata = '0;
      end
   end

   // datapath
   always_comb begin
      mag_in     = mag_ff;
      bit_cnt_in = bit_cnt_ff;
      pos_in     = pos_ff;
      pad_in     = pad_ff;
      dp_in      = dp_ff;
      raw_in     = raw_ff;
      fixed_in   = fixed_ff;
      is_raw_in  = is_raw_ff;
      shown_in   = shown_ff;
      nonneg_in  = nonneg_ff;
      mind_c     = (req_mind > dssf_pkg::MAX_MIN_DIGITS) ? dssf_pkg::MAX_MIN_DIGITS : req_mind;
      if (accept) begin
         nonneg_in  = !req_value[VB-1];
         mag_in     = req_value[VB-1] ? '0 : req_value;
         bit_cnt_in = BB'(VB - 1);
         dp_in      = req_dp;
         raw_in     = req_value[7:0];
         fixed_in   = (req_tuser == dssf_pkg::OP_FIXED);
         is_raw_in  = (req_tuser == dssf_pkg::OP_RAW);
         shown_in   = req_shown;
         pad_in     = (req_tuser == dssf_pkg::OP_FIXED) ? mind_c + {2'b00, req_dp}
                                                        : mind_c;
         pos_in     = '0;
      end
      if (state_ff == dssf_pkg::ST_CONVERT) begin
         mag_in     = {mag_ff[VB-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BB'(1);
      end
      if (state_ff == dssf_pkg::ST_COUNT) begin
         pos_in = run_len - CB'(1);
      end
      if (beat_out && !rsp_tlast) begin
         pos_in = pos_ff - CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dssf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      bit_cnt_ff <= bit_cnt_in;
      pos_ff     <= pos_in;
      pad_ff     <= pad_in;
      dp_ff      <= dp_in;
      raw_ff     <= raw_in;
      fixed_ff   <= fixed_in;
      is_raw_ff  <= is_raw_in;
      shown_ff   <= shown_in;
      nonneg_ff  <= nonneg_in;
   end

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      beat_out && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("run did not end after final beat");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a run is in flight");

   a_convert_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == dssf_pkg::ST_CONVERT && bit_cnt_ff == '0
      |=> state_ff == dssf_pkg::ST_COUNT)
      else $error("conversion did not finish on the last bit");

   a_point_fixed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> is_raw_ff || (fixed_ff && shown_ff))
      else $error("point bit outside fixed mode");

endmodule

`default_nettype wire

/* rtl/dssf_cell.sv */
// ----------------------------------------------------------------------------
// dssf_cell
// One BCD digit of the shift-and-add-3 chain: corrects the digit, shifts in
// the bit from the lower neighbor and hands its top bit to the upper one.
// ----------------------------------------------------------------------------
`default_nettype none

module dssf_cell (
   input  wire                     clock,
   input  dssf_pkg::cell_ctrl_type ctrl,
   input  wire                     carry_in,
   output logic                    carry_out,
   output logic [3:0]              digit
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adjusted;

   always_comb begin
      adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
      carry_out = adjusted[3];
      digit_in  = digit_ff;
      if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.shift) begin
         digit_in = {adjusted[2:0], carry_in};
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

`default_nettype wire
